// ----- hdl/rjb_pkg.sv -----
package rjb_pkg;

    // Default number of reorder slots.
    localparam int SLOTS_DEFAULT = 64;

    // Fixed field widths.
    localparam int SEQ_W    = 16;
    localparam int LEN_W    = 16;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 6;
    localparam int RCOUNT_W = 7;

    // Packet checks.
    localparam logic [LEN_W-1:0]  MIN_PACKET_LEN = 16'd12;
    localparam logic [LEN_W-1:0]  KEEPALIVE_LEN  = 16'd16;
    localparam logic [31:0]       KEEPALIVE_WORD = 32'h0068_3400;
    localparam logic [RCOUNT_W-1:0] RCOUNT_MAX   = 7'd127;

    // Configuration register reset values.
    localparam logic [LEN_W-1:0] MAX_PACKET_LEN_RESET = 16'd32768;
    localparam logic [LEN_W-1:0] FRAME_BYTES_RESET    = 16'd1920;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_MAX_PACKET_LEN = 1'b0,
        REG_FRAME_BYTES    = 1'b1
    } reg_idx_t;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        FUNC_QUEUE   = 2'd0,
        FUNC_DEQUEUE = 2'd1,
        FUNC_RESEND  = 2'd2,
        FUNC_FLUSH   = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [3:0] {
        STAT_STORED    = 4'd0,
        STAT_IGNORED   = 4'd1,
        STAT_BAD_LEN   = 4'd2,
        STAT_AUDIO     = 4'd3,
        STAT_SILENCE   = 4'd4,
        STAT_NOTHING   = 4'd5,
        STAT_RESEND    = 4'd6,
        STAT_NO_RESEND = 4'd7,
        STAT_FLUSHED   = 4'd8
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_INDEX,
        ST_EXEC,
        ST_SCAN,
        ST_SCAN_CHECK,
        ST_DONE
    } state_t;

    // One slot of the reorder memory.
    typedef struct packed {
        logic              valid;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
        logic [LEN_W-1:0]  length;
    } slot_entry_t;

    // One result item.
    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [LEN_W-1:0]    out_length;
        logic [TIME_W-1:0]   out_time;
        logic [SEQ_W-1:0]    resend_first;
        logic [RCOUNT_W-1:0] resend_count;
    } result_t;

endpackage

// ----- hdl/rtp_reorder_jitter_buffer.sv -----
// Reorder buffer for sequence-numbered audio packets, one operation per item (queue, dequeue,
// resend query, flush) and exactly one result item per input item. The slots live in a memory
// with one write and one registered read port; the block works on one item at a time and is
// not ready meanwhile. A queue or dequeue item passes through decode, slot index and memory
// read, update and result; a bad-length, keepalive, late or nothing-to-dequeue item goes from
// decode straight to result, as does a resend query whose head is not before the tail. Other
// resend queries index the head, then read and check each missing slot in turn, stopping at a
// present packet or the tail and walking at most SLOTS slots. A flush, and a queued packet far
// enough ahead to force one, add a clearing pass over all SLOTS slots; the same pass runs after
// reset, and the block first becomes ready once that is done. The slot index is the sequence
// number modulo SLOTS, formed by a reciprocal multiply, so SLOTS need not be a power of two.
// Configuration writes are taken at any time and should only be issued while the block is
// idle.
module rtp_reorder_jitter_buffer #(
    parameter int SLOTS = rjb_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_packet_seq,
    input  logic [31:0] s_packet_time,
    input  logic [15:0] s_packet_length,
    input  logic [31:0] s_payload_head,
    input  logic [15:0] s_decoded_length,
    input  logic        s_no_wait,
    input  logic        s_flush_to_empty,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [5:0]  m_slot,
    output logic [15:0] m_out_length,
    output logic [31:0] m_out_time,
    output logic [15:0] m_resend_first,
    output logic [6:0]  m_resend_count
);
    import rjb_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS + 1);
    // Reciprocal for an exact 16-bit quotient by SLOTS.
    localparam int SH = SEQ_W + $clog2(SLOTS);
    localparam longint unsigned RECIP = ((64'd1 << SH) + SLOTS - 1) / SLOTS;
    localparam int RW = $clog2(RECIP + 1);
    localparam int PW = SEQ_W + RW;
    localparam logic [RW-1:0]    RECIP_C = RW'(RECIP);
    localparam logic [SEQ_W-1:0] SLOTS_SEQ = SEQ_W'(SLOTS);
    localparam logic [IW-1:0]    LAST_IDX = IW'(SLOTS - 1);
    localparam logic [NW-1:0]    SLOTS_N = NW'(SLOTS);

    state_t state_reg, state_next;

    // Held input item.
    func_t             func_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [TIME_W-1:0] time_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [31:0]       phead_reg;
    logic [LEN_W-1:0]  dlen_reg;
    logic              no_wait_reg;
    logic              to_empty_reg;
    logic              pend_reg;

    // Buffer state and configuration.
    logic [SEQ_W-1:0] head_reg;
    logic [SEQ_W-1:0] tail_reg;
    logic             empty_reg;
    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] frame_reg;

    // Index unit, clearing counter and scan walker.
    logic [SEQ_W-1:0] quot_reg;
    logic [SEQ_W-1:0] src_reg;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    clr_reg;
    logic [SEQ_W-1:0] scan_cur_reg;
    logic [NW-1:0]    scan_n_reg;

    result_t res_reg;
    result_t out_reg;
    logic    m_valid_reg;

    // Slot memory ports.
    logic        mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    slot_entry_t mem_wr_data;
    logic        mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    slot_entry_t mem_rd_data;

    logic s_accept;
    logic out_free;

    rjb_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Wrapping sequence compares for the decode, update and scan steps.
    logic [SEQ_W-1:0] seq_minus_head;
    logic [SEQ_W-1:0] seq_minus_far;
    logic [SEQ_W-1:0] win_len;
    logic [SEQ_W-1:0] head_minus_tail;
    logic [SEQ_W-1:0] seq_minus_tail;
    logic [SEQ_W-1:0] cur_minus_tail;
    logic bad_len, keepalive, late, far_ahead, win_none, win_short, resend_any;
    logic seq_after_tail, dup, serve, scan_go;

    assign seq_minus_head  = seq_reg - head_reg;
    assign seq_minus_far   = seq_reg - (head_reg + SLOTS_SEQ);
    assign win_len         = tail_reg - head_reg + 16'd1;
    assign head_minus_tail = head_reg - tail_reg;
    assign seq_minus_tail  = seq_reg - tail_reg;
    assign cur_minus_tail  = scan_cur_reg - tail_reg;

    assign bad_len    = (plen_reg < MIN_PACKET_LEN) || (plen_reg > max_len_reg);
    assign keepalive  = (plen_reg == KEEPALIVE_LEN) && (phead_reg == KEEPALIVE_WORD);
    assign late       = !empty_reg && seq_minus_head[SEQ_W-1];
    assign far_ahead  = !seq_minus_far[SEQ_W-1];
    assign win_none   = empty_reg || win_len[SEQ_W-1] || (win_len == '0);
    assign win_short  = win_len < SLOTS_SEQ;
    assign resend_any = head_minus_tail[SEQ_W-1];

    assign seq_after_tail = !seq_minus_tail[SEQ_W-1] && (seq_minus_tail != '0);
    assign dup            = mem_rd_data.valid && (mem_rd_data.seq == seq_reg);
    assign serve          = mem_rd_data.valid || no_wait_reg || !win_short;
    assign scan_go        = (scan_n_reg < SLOTS_N) && cur_minus_tail[SEQ_W-1];

    // Status settled at decode; later steps may replace it.
    status_t dec_status;

    always_comb begin
        priority if (func_reg == FUNC_DEQUEUE) begin
            dec_status = STAT_NOTHING;
        end else if (func_reg == FUNC_RESEND) begin
            dec_status = STAT_NO_RESEND;
        end else if (func_reg == FUNC_FLUSH) begin
            dec_status = STAT_FLUSHED;
        end else if (bad_len) begin
            dec_status = STAT_BAD_LEN;
        end else if (keepalive || late) begin
            dec_status = STAT_IGNORED;
        end else begin
            dec_status = STAT_STORED;
        end
    end

    // Index unit: quotient by reciprocal, registered, then remainder from the registered quotient.
    logic [SEQ_W-1:0] idx_src;
    logic [PW-1:0]    quot_prod;
    logic [SEQ_W-1:0] quot_calc;
    logic [SEQ_W-1:0] quot_times;
    logic [SEQ_W-1:0] rem_calc;
    logic [IW-1:0]    idx_calc;

    assign idx_src    = (func_reg == FUNC_QUEUE) ? seq_reg : head_reg;
    assign quot_prod  = PW'(idx_src) * PW'(RECIP_C);
    assign quot_calc  = SEQ_W'(quot_prod >> SH);
    assign quot_times = SEQ_W'(32'(quot_reg) * 32'(SLOTS_SEQ));
    assign rem_calc   = src_reg - quot_times;
    assign idx_calc   = rem_calc[IW-1:0];

    // Slot index as seen on the result port.
    logic [IW+SLOT_W-1:0] idx_wide;
    assign idx_wide = {{SLOT_W{1'b0}}, idx_reg};

    // Resend count, saturated.
    logic [NW+RCOUNT_W-1:0] scan_n_wide;
    logic [RCOUNT_W-1:0]    scan_count;
    assign scan_n_wide = {{RCOUNT_W{1'b0}}, scan_n_reg};
    assign scan_count  = (scan_n_wide > (NW+RCOUNT_W)'(RCOUNT_MAX)) ? RCOUNT_MAX
                                                                    : scan_n_wide[RCOUNT_W-1:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_IDX) begin
                    if (!pend_reg) begin
                        state_next = ST_IDLE;
                    end else if (func_reg == FUNC_FLUSH) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_INDEX;
                    end
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (func_reg)
                    FUNC_QUEUE: begin
                        priority if (bad_len || keepalive || late) begin
                            state_next = ST_DONE;
                        end else if (far_ahead) begin
                            state_next = ST_CLEAR;
                        end else begin
                            state_next = ST_INDEX;
                        end
                    end
                    FUNC_DEQUEUE: state_next = win_none ? ST_DONE : ST_INDEX;
                    FUNC_RESEND:  state_next = resend_any ? ST_INDEX : ST_DONE;
                    FUNC_FLUSH:   state_next = ST_CLEAR;
                endcase
            end
            ST_INDEX: begin
                state_next = (func_reg == FUNC_RESEND) ? ST_SCAN : ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                state_next = scan_go ? ST_SCAN_CHECK : ST_DONE;
            end
            ST_SCAN_CHECK: begin
                state_next = mem_rd_data.valid ? ST_DONE : ST_SCAN;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory control and handshake outputs.
    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
            end
            ST_INDEX: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_calc;
            end
            ST_EXEC: begin
                if (func_reg == FUNC_QUEUE) begin
                    mem_wr_en   = !dup;
                    mem_wr_data = '{valid: 1'b1, seq: seq_reg, stamp: time_reg, length: dlen_reg};
                end else begin
                    // A served packet frees its slot.
                    mem_wr_en = serve && mem_rd_data.valid;
                end
            end
            ST_SCAN: begin
                mem_rd_en = scan_go;
            end
            default: begin
            end
        endcase
    end

    // Sequencer state and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (s_accept) begin
                pend_reg <= 1'b1;
            end

            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (state_reg == ST_DECODE) begin
                if (func_reg == FUNC_QUEUE && !bad_len && !keepalive && !late && far_ahead) begin
                    head_reg <= seq_reg;
                    tail_reg <= seq_reg - 16'd1;
                    clr_reg  <= '0;
                end
                if (func_reg == FUNC_FLUSH) begin
                    clr_reg <= '0;
                    if (to_empty_reg) begin
                        empty_reg <= 1'b1;
                    end else begin
                        head_reg <= seq_reg;
                        tail_reg <= seq_reg - 16'd1;
                    end
                end
            end

            if (state_reg == ST_EXEC) begin
                if (func_reg == FUNC_QUEUE) begin
                    if (!dup) begin
                        if (empty_reg) begin
                            head_reg  <= seq_reg;
                            tail_reg  <= seq_reg;
                            empty_reg <= 1'b0;
                        end else if (seq_after_tail) begin
                            tail_reg <= seq_reg;
                        end
                    end
                end else if (serve) begin
                    head_reg <= head_reg + 16'd1;
                end
            end

            // Output register.
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                pend_reg    <= 1'b0;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_PACKET_LEN_RESET;
            frame_reg   <= FRAME_BYTES_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MAX_PACKET_LEN: max_len_reg <= cfg_wr_data;
                REG_FRAME_BYTES:    frame_reg   <= cfg_wr_data;
            endcase
        end
    end

    // Item, index, scan and result payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg     <= func_t'(s_func);
            seq_reg      <= s_packet_seq;
            time_reg     <= s_packet_time;
            plen_reg     <= s_packet_length;
            phead_reg    <= s_payload_head;
            dlen_reg     <= s_decoded_length;
            no_wait_reg  <= s_no_wait;
            to_empty_reg <= s_flush_to_empty;
        end

        unique case (state_reg)
            ST_DECODE: begin
                quot_reg     <= quot_calc;
                src_reg      <= idx_src;
                scan_cur_reg <= head_reg;
                scan_n_reg   <= '0;
                res_reg      <= '{status: dec_status, slot: '0, out_length: '0, out_time: '0,
                                  resend_first: '0, resend_count: '0};
            end
            ST_INDEX: begin
                idx_reg <= idx_calc;
            end
            ST_EXEC: begin
                if (func_reg == FUNC_QUEUE) begin
                    if (dup) begin
                        res_reg.status <= STAT_IGNORED;
                    end else begin
                        res_reg.status <= STAT_STORED;
                        res_reg.slot   <= idx_wide[SLOT_W-1:0];
                    end
                end else if (serve) begin
                    res_reg.slot <= idx_wide[SLOT_W-1:0];
                    if (mem_rd_data.valid) begin
                        res_reg.status     <= STAT_AUDIO;
                        res_reg.out_length <= mem_rd_data.length;
                        res_reg.out_time   <= mem_rd_data.stamp;
                    end else begin
                        res_reg.status     <= STAT_SILENCE;
                        res_reg.out_length <= frame_reg;
                    end
                end
            end
            ST_SCAN: begin
                if (!scan_go && scan_n_reg != '0) begin
                    res_reg.status       <= STAT_RESEND;
                    res_reg.resend_first <= head_reg;
                    res_reg.resend_count <= scan_count;
                end
            end
            ST_SCAN_CHECK: begin
                if (mem_rd_data.valid) begin
                    if (scan_n_reg != '0) begin
                        res_reg.status       <= STAT_RESEND;
                        res_reg.resend_first <= head_reg;
                        res_reg.resend_count <= scan_count;
                    end
                end else begin
                    // Step to the next slot, wrapping at the end of the memory and where the
                    // sequence number itself wraps to zero.
                    scan_cur_reg <= scan_cur_reg + 16'd1;
                    scan_n_reg   <= scan_n_reg + 1'b1;
                    idx_reg      <= (idx_reg == LAST_IDX || scan_cur_reg == '1) ? '0
                                                                               : idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_reg <= res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_reg.status;
    assign m_slot         = out_reg.slot;
    assign m_out_length   = out_reg.out_length;
    assign m_out_time     = out_reg.out_time;
    assign m_resend_first = out_reg.resend_first;
    assign m_resend_count = out_reg.resend_count;

    // A result only appears after the sequencer has finished an item.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the completion state");

    // An accepted item is always decoded in the following cycle.
    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_DECODE)
        else $error("accepted item not decoded");

    // The resend walk never looks past the whole slot memory.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN_CHECK |-> scan_n_reg < SLOTS_N)
        else $error("resend scan ran beyond the slot count");

    // No slot is written while the resend walk is reading.
    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_SCAN_CHECK) |-> !mem_wr_en)
        else $error("slot memory written during resend scan");

endmodule

// ----- hdl/rjb_slot_ram.sv -----
module rjb_slot_ram #(
    parameter int DEPTH = rjb_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  rjb_pkg::slot_entry_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output rjb_pkg::slot_entry_t rd_data
);
    import rjb_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- verif/rtp_reorder_jitter_buffer_tb.sv -----
`timescale 1ns / 100ps

module rtp_reorder_jitter_buffer_tb;
    import rjb_pkg::*;

    localparam int SLOT_COUNT = 64;

    // One input item as the testbench sees it.
    typedef struct packed {
        func_t       func;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [15:0] length;
        logic [31:0] head_word;
        logic [15:0] dec_len;
        logic        no_wait;
        logic        to_empty;
    } pkt_op_t;

    // One row of the directed plan; typed rows carry their answer.
    typedef struct {
        pkt_op_t op;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = REG_MAX_PACKET_LEN;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_QUEUE;
    logic [15:0] s_packet_seq = '0;
    logic [31:0] s_packet_time = '0;
    logic [15:0] s_packet_length = '0;
    logic [31:0] s_payload_head = '0;
    logic [15:0] s_decoded_length = '0;
    logic        s_no_wait = 1'b0;
    logic        s_flush_to_empty = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic [5:0]  m_slot;
    logic [15:0] m_out_length;
    logic [31:0] m_out_time;
    logic [15:0] m_resend_first;
    logic [6:0]  m_resend_count;

    // Mirror of the buffer held by the testbench.
    bit          slot_full  [SLOT_COUNT];
    bit [15:0]   slot_seqno [SLOT_COUNT];
    bit [31:0]   slot_stamp [SLOT_COUNT];
    bit [15:0]   slot_bytes [SLOT_COUNT];
    bit [15:0]   win_head = '0;
    bit [15:0]   win_tail = '0;
    bit          buf_empty = 1'b1;
    bit [15:0]   lim_len = MAX_PACKET_LEN_RESET;
    bit [15:0]   silence_len = FRAME_BYTES_RESET;

    result_t     expected_q[$];
    int          fail_count = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    rtp_reorder_jitter_buffer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_packet_seq     (s_packet_seq),
        .s_packet_time    (s_packet_time),
        .s_packet_length  (s_packet_length),
        .s_payload_head   (s_payload_head),
        .s_decoded_length (s_decoded_length),
        .s_no_wait        (s_no_wait),
        .s_flush_to_empty (s_flush_to_empty),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot           (m_slot),
        .m_out_length     (m_out_length),
        .m_out_time       (m_out_time),
        .m_resend_first   (m_resend_first),
        .m_resend_count   (m_resend_count)
    );

    // Clock generation.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Sequence numbers wrap, so they are compared as signed 16-bit differences.
    function automatic int seq_diff(logic [15:0] a, logic [15:0] b);
        logic signed [15:0] d;
        d = a - b;
        return int'(d);
    endfunction

    function automatic void clear_slots();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_full[i] = 1'b0;
            slot_bytes[i] = '0;
        end
    endfunction

    // Applies one item to the mirrored buffer and returns the result it should give.
    function automatic result_t advance_buffer(pkt_op_t op);
        result_t     r;
        int          idx;
        int          span;
        int          n;
        logic [15:0] s;
        r = '0;
        r.status = STAT_NOTHING;
        case (op.func)
            FUNC_QUEUE: begin
                if (op.length < MIN_PACKET_LEN || op.length > lim_len) begin
                    r.status = STAT_BAD_LEN;
                end else if (op.length == KEEPALIVE_LEN && op.head_word == KEEPALIVE_WORD) begin
                    r.status = STAT_IGNORED;
                end else if (!buf_empty && seq_diff(op.seq, win_head) < 0) begin
                    r.status = STAT_IGNORED;
                end else begin
                    // A packet a whole window ahead restarts the buffer at its number.
                    if (seq_diff(op.seq, win_head + 16'(SLOT_COUNT)) >= 0) begin
                        clear_slots();
                        win_head = op.seq;
                        win_tail = op.seq - 16'd1;
                    end
                    idx = op.seq % SLOT_COUNT;
                    if (slot_full[idx] && slot_seqno[idx] == op.seq) begin
                        r.status = STAT_IGNORED;
                    end else begin
                        slot_full[idx] = 1'b1;
                        slot_seqno[idx] = op.seq;
                        slot_stamp[idx] = op.stamp;
                        slot_bytes[idx] = op.dec_len;
                        if (buf_empty) begin
                            win_head = op.seq;
                            win_tail = op.seq;
                            buf_empty = 1'b0;
                        end
                        if (seq_diff(op.seq, win_tail) > 0) begin
                            win_tail = op.seq;
                        end
                        r.status = STAT_STORED;
                        r.slot = 6'(idx);
                    end
                end
            end
            FUNC_DEQUEUE: begin
                span = seq_diff(win_tail - win_head + 16'd1, 16'd0);
                idx = win_head % SLOT_COUNT;
                // A missing head is waited for unless told not to or the window is full.
                if (!buf_empty && span > 0 &&
                    (op.no_wait || slot_full[idx] || span >= SLOT_COUNT)) begin
                    win_head = win_head + 16'd1;
                    r.slot = 6'(idx);
                    if (!slot_full[idx]) begin
                        r.status = STAT_SILENCE;
                        r.out_length = silence_len;
                    end else begin
                        slot_full[idx] = 1'b0;
                        r.status = STAT_AUDIO;
                        r.out_length = slot_bytes[idx];
                        r.out_time = slot_stamp[idx];
                        slot_bytes[idx] = '0;
                    end
                end
            end
            FUNC_RESEND: begin
                r.status = STAT_NO_RESEND;
                if (seq_diff(win_head, win_tail) < 0) begin
                    s = win_head;
                    n = 0;
                    while (n < SLOT_COUNT && seq_diff(s, win_tail) < 0 &&
                           !slot_full[s % SLOT_COUNT]) begin
                        s = s + 16'd1;
                        n++;
                    end
                    if (n != 0) begin
                        r.status = STAT_RESEND;
                        r.resend_first = win_head;
                        r.resend_count = (n > 127) ? RCOUNT_MAX : n[6:0];
                    end
                end
            end
            default: begin
                clear_slots();
                if (op.to_empty) begin
                    buf_empty = 1'b1;
                end else begin
                    win_head = op.seq;
                    win_tail = op.seq - 16'd1;
                end
                r.status = STAT_FLUSHED;
            end
        endcase
        return r;
    endfunction

    // Builders for directed rows.
    function automatic pkt_op_t q_op(logic [15:0] seq, logic [31:0] stamp, logic [15:0] length,
                                     logic [31:0] head_word, logic [15:0] dec_len);
        pkt_op_t op;
        op = '0;
        op.func = FUNC_QUEUE;
        op.seq = seq;
        op.stamp = stamp;
        op.length = length;
        op.head_word = head_word;
        op.dec_len = dec_len;
        return op;
    endfunction

    function automatic pkt_op_t d_op(logic no_wait);
        pkt_op_t op;
        op = '0;
        op.func = FUNC_DEQUEUE;
        op.no_wait = no_wait;
        return op;
    endfunction

    function automatic pkt_op_t r_op();
        pkt_op_t op;
        op = '0;
        op.func = FUNC_RESEND;
        return op;
    endfunction

    function automatic pkt_op_t f_op(logic [15:0] seq, logic to_empty);
        pkt_op_t op;
        op = '0;
        op.func = FUNC_FLUSH;
        op.seq = seq;
        op.to_empty = to_empty;
        return op;
    endfunction

    function automatic result_t res(status_t status, logic [5:0] slot, logic [15:0] length,
                                    logic [31:0] stamp, logic [15:0] first, logic [6:0] count);
        result_t r;
        r.status = status;
        r.slot = slot;
        r.out_length = length;
        r.out_time = stamp;
        r.resend_first = first;
        r.resend_count = count;
        return r;
    endfunction

    // Random item, mostly a packet stream jittering around the current head.
    function automatic pkt_op_t random_op();
        pkt_op_t op;
        int      pick;
        int      span;
        op.stamp = $urandom;
        op.head_word = $urandom;
        op.dec_len = 16'($urandom);
        op.no_wait = ($urandom_range(0, 3) == 0);
        op.to_empty = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 52) begin
            op.func = FUNC_QUEUE;
        end else if (pick < 82) begin
            op.func = FUNC_DEQUEUE;
        end else if (pick < 95) begin
            op.func = FUNC_RESEND;
        end else begin
            op.func = FUNC_FLUSH;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            op.seq = win_head + 16'($urandom_range(0, 40));
        end else if (pick < 82) begin
            op.seq = win_head + 16'($urandom_range(41, 80));
        end else if (pick < 94) begin
            op.seq = win_head - 16'($urandom_range(1, 6));
        end else begin
            op.seq = 16'($urandom);
        end
        // Lengths are mostly legal and short, with the edges and keepalives mixed in.
        pick = $urandom_range(0, 99);
        span = int'(lim_len) - 12;
        if (span > 300) span = 300;
        if (pick < 80) begin
            op.length = 16'(12 + $urandom_range(0, span));
        end else if (pick < 86) begin
            op.length = lim_len;
        end else if (pick < 90) begin
            op.length = 16'($urandom_range(0, 11));
        end else if (pick < 94 && lim_len != 16'hFFFF) begin
            op.length = 16'($urandom_range(int'(lim_len) + 1, 65535));
        end else if (pick < 98) begin
            op.length = KEEPALIVE_LEN;
            if ($urandom_range(0, 3) != 0) op.head_word = KEEPALIVE_WORD;
        end else begin
            op.length = 16'($urandom);
        end
        return op;
    endfunction

    // Offers one item, records its expected result on acceptance and keeps valid
    // high only when the next item follows straight on.
    task automatic issue(pkt_op_t op, bit typed, result_t want, bit more);
        int      gap;
        result_t model_res;
        s_valid <= 1'b1;
        s_func <= op.func;
        s_packet_seq <= op.seq;
        s_packet_time <= op.stamp;
        s_packet_length <= op.length;
        s_payload_head <= op.head_word;
        s_decoded_length <= op.dec_len;
        s_no_wait <= op.no_wait;
        s_flush_to_empty <= op.to_empty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model_res = advance_buffer(op);
        expected_q.push_back(typed ? want : model_res);
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
        if (!more || gap != 0) s_valid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    // Writes both registers back to back.
    task automatic apply_settings(logic [15:0] max_len, logic [15:0] frame);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_PACKET_LEN;
        cfg_wr_data <= max_len;
        @(posedge aclk);
        lim_len = max_len;
        cfg_index <= REG_FRAME_BYTES;
        cfg_wr_data <= frame;
        @(posedge aclk);
        silence_len = frame;
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every expected result has come back.
    task automatic settle();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_result(result_t want, result_t got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            fail_count++;
        end
        if (got.out_length !== want.out_length) begin
            $error("out_length: expected %0d, got %0d", want.out_length, got.out_length);
            fail_count++;
        end
        if (got.out_time !== want.out_time) begin
            $error("out_time: expected %0h, got %0h", want.out_time, got.out_time);
            fail_count++;
        end
        if (got.resend_first !== want.resend_first) begin
            $error("resend_first: expected %0d, got %0d", want.resend_first, got.resend_first);
            fail_count++;
        end
        if (got.resend_count !== want.resend_count) begin
            $error("resend_count: expected %0d, got %0d", want.resend_count, got.resend_count);
            fail_count++;
        end
    endtask

    // Result side: random stall bursts while idling is allowed.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every accepted result item is checked against the oldest expectation.
    always @(posedge aclk) begin : collect
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status = status_t'(m_status);
            got.slot = m_slot;
            got.out_length = m_out_length;
            got.out_time = m_out_time;
            got.resend_first = m_resend_first;
            got.resend_count = m_resend_count;
            if (expected_q.size() == 0) begin
                $error("result item with none expected: status %0d", m_status);
                fail_count++;
            end else begin
                check_result(expected_q.pop_front(), got);
            end
        end
    end

    // Stimulus: directed plan, then random phases under several register settings.
    initial begin : stimulus
        plan_row_t plan[$];
        int        k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        plan.push_back('{d_op(1'b0), 1'b1, res(STAT_NOTHING, 0, 0, 0, 0, 0)});
        plan.push_back('{r_op(), 1'b1, res(STAT_NO_RESEND, 0, 0, 0, 0, 0)});
        plan.push_back('{q_op(16'd5, 32'd1, 16'd11, 32'd0, 16'd7), 1'b1,
                         res(STAT_BAD_LEN, 0, 0, 0, 0, 0)});
        plan.push_back('{q_op(16'd5, 32'd1, 16'hFFFF, 32'd0, 16'd7), 1'b1,
                         res(STAT_BAD_LEN, 0, 0, 0, 0, 0)});
        plan.push_back('{q_op(16'd5, 32'd1, KEEPALIVE_LEN, KEEPALIVE_WORD, 16'd7), 1'b1,
                         res(STAT_IGNORED, 0, 0, 0, 0, 0)});
        plan.push_back('{q_op(16'd100, 32'hFFFF_FFFF, 16'd12, 32'hFFFF_FFFF, 16'hFFFF), 1'b1,
                         res(STAT_STORED, 6'd36, 0, 0, 0, 0)});
        // Duplicate of the stored packet, then one behind the head.
        plan.push_back('{q_op(16'd100, 32'h1234, 16'd20, 32'd0, 16'd5), 1'b1,
                         res(STAT_IGNORED, 0, 0, 0, 0, 0)});
        plan.push_back('{q_op(16'd99, 32'h1234, 16'd20, 32'd0, 16'd5), 1'b1,
                         res(STAT_IGNORED, 0, 0, 0, 0, 0)});
        plan.push_back('{q_op(16'd103, 32'd0, 16'd32768, KEEPALIVE_WORD, 16'd0), 1'b0, '0});
        plan.push_back('{r_op(), 1'b0, '0});
        plan.push_back('{d_op(1'b0), 1'b1,
                         res(STAT_AUDIO, 6'd36, 16'hFFFF, 32'hFFFF_FFFF, 0, 0)});
        plan.push_back('{r_op(), 1'b0, '0});
        // Missing head: first waited for, then skipped as silence.
        plan.push_back('{d_op(1'b0), 1'b0, '0});
        plan.push_back('{d_op(1'b1), 1'b1,
                         res(STAT_SILENCE, 6'd37, FRAME_BYTES_RESET, 0, 0, 0)});
        // A packet a whole window ahead forces a restart.
        plan.push_back('{q_op(16'd166, 32'hA5A5_5A5A, 16'd40, 32'd0, 16'd300), 1'b0, '0});
        plan.push_back('{f_op(16'hFFFF, 1'b0), 1'b1, res(STAT_FLUSHED, 0, 0, 0, 0, 0)});
        plan.push_back('{d_op(1'b0), 1'b0, '0});
        plan.push_back('{q_op(16'd0, 32'h0BAD_F00D, 16'd64, 32'd0, 16'd960), 1'b0, '0});
        plan.push_back('{r_op(), 1'b0, '0});
        plan.push_back('{d_op(1'b0), 1'b0, '0});
        // Fill the window to its full length, so a missing head is not waited for.
        plan.push_back('{q_op(16'd62, 32'h5555_AAAA, 16'd100, 32'd0, 16'd480), 1'b0, '0});
        plan.push_back('{d_op(1'b0), 1'b0, '0});
        // Longest missing run the window allows.
        plan.push_back('{f_op(16'h8000, 1'b0), 1'b1, res(STAT_FLUSHED, 0, 0, 0, 0, 0)});
        plan.push_back('{q_op(16'h803F, 32'h0000_0001, 16'd200, 32'd0, 16'd1), 1'b0, '0});
        plan.push_back('{r_op(), 1'b0, '0});
        plan.push_back('{f_op(16'd0, 1'b1), 1'b1, res(STAT_FLUSHED, 0, 0, 0, 0, 0)});
        plan.push_back('{d_op(1'b1), 1'b1, res(STAT_NOTHING, 0, 0, 0, 0, 0)});

        foreach (plan[i]) begin
            issue(plan[i].op, plan[i].typed, plan[i].want, i < plan.size() - 1);
        end
        settle();

        // Random phases; the last one runs at full rate on both sides.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: apply_settings(MIN_PACKET_LEN, 16'd1);
                1: apply_settings(16'hFFFF, 16'hFFFF);
                2: apply_settings(16'($urandom_range(200, 40000)), 16'($urandom_range(1, 65535)));
                3: apply_settings(16'd100, 16'd480);
                default: apply_settings(MAX_PACKET_LEN_RESET, FRAME_BYTES_RESET);
            endcase
            for (k = 0; k < 340; k++) begin
                if (k % 40 == 0) idle_on = (phase != 4) && ($urandom_range(0, 3) != 0);
                issue(random_op(), 1'b0, '0, k < 339);
            end
            settle();
        end

        repeat (200) @(posedge aclk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("PASS rtp_reorder_jitter_buffer");
        end else begin
            $display("FAIL rtp_reorder_jitter_buffer");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #25_000_000;
        $display("FAIL rtp_reorder_jitter_buffer");
        $finish;
    end

endmodule
